FILE: rtl/core/assert_macros.svh
// Assertion macros for the segmenter RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising aclk edge outside reset.
`define FCRS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// Check that an antecedent is always followed by a consequent in the next cycle.
`define FCRS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/fcrs_pkg.sv
// Types and constants of the floor colour range segmenter.
`default_nettype none

package fcrs_pkg;

    // Field widths
    localparam int unsigned CfgW   = 12;
    localparam int unsigned DimW   = 13;  // clamped dimension, up to MAX_DIM
    localparam int unsigned SignW  = 15;  // signed working width for bounds
    localparam int unsigned ChanW  = 8;
    localparam int unsigned DiffW  = 10;
    localparam int unsigned CountW = 23;

    // Register indexes
    typedef enum logic [1:0] {
        REG_IMAGE_WIDTH  = 2'd0,
        REG_IMAGE_HEIGHT = 2'd1,
        REG_RECT_WIDTH   = 2'd2,
        REG_RECT_HEIGHT  = 2'd3
    } cfg_index_t;

    // Pixel kinds
    typedef enum logic {
        REQ_LEARN    = 1'b0,
        REQ_CLASSIFY = 1'b1
    } req_type_t;

    // Statistic reset values
    localparam logic [ChanW-1:0]        RedLowReset  = 8'd255;
    localparam logic signed [DiffW-1:0] DiffLowReset = 10'sd255;
    localparam logic [CountW-1:0]       CountMax     = {CountW{1'b1}};

    // Position information handed from the position tracker
    typedef struct packed {
        logic in_rect;
        logic last_col;
        logic last_row;
    } pos_info_t;

endpackage

`default_nettype wire

FILE: rtl/core/floor_color_range_segmenter.sv
// Top level of the floor colour range segmenter.
//
//  channel  direction  handshake          payload
//  s_       in         s_tvalid/s_tready  s_tdata: red, green, blue; s_tuser: req_type, frame_start
//  m_       out        m_tvalid/m_tready  m_tdata: floor_mask, floor_count; m_tlast: frame_end
//  cfg_     in         cfg_wr_en          cfg_index, cfg_data (no read-back)
//
// One pixel a cycle sustained unless a classify pixel waits on a stalled, full
// result register; a classify word moves from the input register to the result
// register. Learn pixels give no word. The loop through the position, statistics
// and count registers sets the rate. Reset is synchronous, no clearing pass. A
// stalled result register holds only classify pixels; learn pixels pass on.
`default_nettype none

`include "assert_macros.svh"

module floor_color_range_segmenter #(
    parameter int unsigned MAX_DIM = 2048
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // Pixel input
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [23:0] s_tdata,   // red [7:0], green [15:8], blue [23:16]
    input  wire logic [1:0]  s_tuser,   // req_type [0], frame_start [1]
    // Result output
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata,   // floor_mask [0], floor_count [23:1]
    output logic             m_tlast,
    // Configuration
    input  wire logic        cfg_wr_en,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [11:0] cfg_data
);

    // Configuration registers
    logic [fcrs_pkg::CfgW-1:0] width_reg, height_reg, rect_w_reg, rect_h_reg;

    // Input stage
    logic                       in_valid_reg;
    fcrs_pkg::req_type_t        in_req_reg;
    logic                       in_fs_reg;
    logic [fcrs_pkg::ChanW-1:0] in_red_reg, in_green_reg, in_blue_reg;

    // Result stage and count
    logic                        out_valid_reg;
    logic                        out_mask_reg;
    logic [fcrs_pkg::CountW-1:0] out_count_reg;
    logic                        out_end_reg;
    logic [fcrs_pkg::CountW-1:0] total_reg, total_next, total_base;

    fcrs_pkg::pos_info_t pos_info;
    logic advance, classify, hit;

    // Write configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= 12'd640;
            height_reg <= 12'd480;
            rect_w_reg <= 12'd64;
            rect_h_reg <= 12'd32;
        end else if (cfg_wr_en) begin
            case (fcrs_pkg::cfg_index_t'(cfg_index))
                fcrs_pkg::REG_IMAGE_WIDTH:  width_reg  <= cfg_data;
                fcrs_pkg::REG_IMAGE_HEIGHT: height_reg <= cfg_data;
                fcrs_pkg::REG_RECT_WIDTH:   rect_w_reg <= cfg_data;
                fcrs_pkg::REG_RECT_HEIGHT:  rect_h_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Advance the held word when it needs no slot or its slot frees
    assign classify = (in_req_reg == fcrs_pkg::REQ_CLASSIFY);
    assign advance  = in_valid_reg && (!classify || !out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    // Hold the accepted pixel
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_req_reg   <= fcrs_pkg::req_type_t'(s_tuser[0]);
            in_fs_reg    <= s_tuser[1];
            in_red_reg   <= s_tdata[7:0];
            in_green_reg <= s_tdata[15:8];
            in_blue_reg  <= s_tdata[23:16];
        end
    end

    fcrs_position #(
        .MAX_DIM(MAX_DIM)
    ) u_position (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .step        (advance),
        .frame_start (in_fs_reg),
        .image_width (width_reg),
        .image_height(height_reg),
        .rect_width  (rect_w_reg),
        .rect_height (rect_h_reg),
        .info        (pos_info)
    );

    fcrs_colour_stats u_stats (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .step       (advance),
        .req_type   (in_req_reg),
        .frame_start(in_fs_reg),
        .in_rect    (pos_info.in_rect),
        .red        (in_red_reg),
        .green      (in_green_reg),
        .blue       (in_blue_reg),
        .hit        (hit)
    );

    // Saturating floor count, cleared by a classify frame start
    assign total_base = in_fs_reg ? '0 : total_reg;
    assign total_next = (hit && (total_base != fcrs_pkg::CountMax)) ?
                        total_base + 1'b1 : total_base;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            total_reg <= '0;
        end else if (advance && classify) begin
            total_reg <= total_next;
        end
    end

    // Load or drop the result word
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance && classify) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && classify) begin
            out_mask_reg  <= hit;
            out_count_reg <= total_next;
            out_end_reg   <= pos_info.last_col && pos_info.last_row;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_count_reg, out_mask_reg};
    assign m_tlast  = out_end_reg;

    // A classify pixel that moves on always yields a word
    `FCRS_ASSERT_NEXT(a_classify_gives_word, advance && classify, m_tvalid,
                      "classify pixel produced no result word")
    // A floor pixel leaves a nonzero count
    `FCRS_ASSERT_NEXT(a_hit_counts, advance && classify && hit, m_tdata[23:1] != '0,
                      "floor pixel left a zero count")
    // A held pixel that cannot move stays held
    `FCRS_ASSERT_NEXT(a_stall_holds, in_valid_reg && !advance, in_valid_reg,
                      "stalled input word was lost")
    // A learn pixel never waits on the result side
    `FCRS_ASSERT(a_learn_flows, !(in_valid_reg && !classify) || advance,
                 "learn pixel stalled")

endmodule

`default_nettype wire

FILE: rtl/core/fcrs_position.sv
// Raster position tracker and reference rectangle test.
`default_nettype none

module fcrs_position #(
    parameter int unsigned MAX_DIM = 2048
) (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      step,
    input  wire logic                      frame_start,
    input  wire logic [fcrs_pkg::CfgW-1:0] image_width,
    input  wire logic [fcrs_pkg::CfgW-1:0] image_height,
    input  wire logic [fcrs_pkg::CfgW-1:0] rect_width,
    input  wire logic [fcrs_pkg::CfgW-1:0] rect_height,
    output fcrs_pkg::pos_info_t            info
);

    localparam int unsigned PosW = $clog2(MAX_DIM);
    localparam logic [fcrs_pkg::DimW-1:0] MaxDim = fcrs_pkg::DimW'(MAX_DIM);

    logic [PosW-1:0] col_reg, col_next;
    logic [PosW-1:0] row_reg, row_next;

    logic [PosW-1:0]              x, y;
    logic [fcrs_pkg::DimW-1:0]    w, h;
    logic [fcrs_pkg::DimW:0]      x_inc, y_inc;
    logic signed [fcrs_pkg::SignW-1:0] xs, ys, ws, hs, rws, rhs;
    logic signed [fcrs_pkg::SignW-1:0] up_s, left_s, right_s;

    // Clamp dimensions to the supported maximum
    always_comb begin
        w = ({1'b0, image_width} > MaxDim) ? MaxDim : {1'b0, image_width};
        h = ({1'b0, image_height} > MaxDim) ? MaxDim : {1'b0, image_height};
    end

    // Position of this pixel: a frame start restarts at the origin
    assign x = frame_start ? '0 : col_reg;
    assign y = frame_start ? '0 : row_reg;

    assign x_inc = (fcrs_pkg::DimW + 1)'(x) + 1'b1;
    assign y_inc = (fcrs_pkg::DimW + 1)'(y) + 1'b1;

    // Rectangle bounds as signed values; the bound before the shift can be
    // negative, and an arithmetic shift then rounds it toward minus infinity
    always_comb begin
        xs      = $signed(fcrs_pkg::SignW'(x));
        ys      = $signed(fcrs_pkg::SignW'(y));
        ws      = $signed(fcrs_pkg::SignW'(w));
        hs      = $signed(fcrs_pkg::SignW'(h));
        rws     = $signed(fcrs_pkg::SignW'(rect_width));
        rhs     = $signed(fcrs_pkg::SignW'(rect_height));
        up_s    = hs - rhs;
        left_s  = (ws - rws - fcrs_pkg::SignW'(1)) >>> 1;
        right_s = (ws + rws - fcrs_pkg::SignW'(1)) >>> 1;
    end

    always_comb begin
        info.in_rect  = (ys >= up_s) && (ys < hs) && (xs >= left_s) && (xs < right_s);
        info.last_col = (x_inc >= (fcrs_pkg::DimW + 1)'(w));
        info.last_row = (y_inc >= (fcrs_pkg::DimW + 1)'(h));
    end

    // Advance in raster order, wrapping at the end of a frame
    always_comb begin
        col_next = col_reg;
        row_next = row_reg;
        if (step) begin
            if (info.last_col) begin
                col_next = '0;
                row_next = info.last_row ? '0 : PosW'(y_inc);
            end else begin
                col_next = PosW'(x_inc);
                row_next = y;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            row_reg <= '0;
        end else begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/fcrs_colour_stats.sv
// Learned colour range statistics and floor test.
`default_nettype none

module fcrs_colour_stats (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       step,
    input  wire fcrs_pkg::req_type_t        req_type,
    input  wire logic                       frame_start,
    input  wire logic                       in_rect,
    input  wire logic [fcrs_pkg::ChanW-1:0] red,
    input  wire logic [fcrs_pkg::ChanW-1:0] green,
    input  wire logic [fcrs_pkg::ChanW-1:0] blue,
    output logic                            hit
);

    logic [fcrs_pkg::ChanW-1:0]        red_low_reg, red_low_next;
    logic [fcrs_pkg::ChanW-1:0]        red_high_reg, red_high_next;
    logic signed [fcrs_pkg::DiffW-1:0] rg_low_reg, rg_low_next;
    logic signed [fcrs_pkg::DiffW-1:0] rg_high_reg, rg_high_next;
    logic signed [fcrs_pkg::DiffW-1:0] rb_low_reg, rb_low_next;
    logic signed [fcrs_pkg::DiffW-1:0] rb_high_reg, rb_high_next;

    logic signed [fcrs_pkg::DiffW-1:0] rg, rb;
    logic learn, restart, take;

    // Colour differences
    assign rg = $signed({2'b00, red}) - $signed({2'b00, green});
    assign rb = $signed({2'b00, red}) - $signed({2'b00, blue});

    assign learn   = (req_type == fcrs_pkg::REQ_LEARN);
    assign restart = learn && frame_start;
    assign take    = learn && in_rect && ((red | green | blue) != '0);

    // Reset the ranges on a learn frame start and widen them over non-black reference pixels
    always_comb begin
        red_low_next  = restart ? fcrs_pkg::RedLowReset  : red_low_reg;
        red_high_next = restart ? '0                     : red_high_reg;
        rg_low_next   = restart ? fcrs_pkg::DiffLowReset : rg_low_reg;
        rg_high_next  = restart ? '0                     : rg_high_reg;
        rb_low_next   = restart ? fcrs_pkg::DiffLowReset : rb_low_reg;
        rb_high_next  = restart ? '0                     : rb_high_reg;
        if (take) begin
            if (red < red_low_next)  red_low_next  = red;
            if (red > red_high_next) red_high_next = red;
            if (rg < rg_low_next)    rg_low_next   = rg;
            if (rg > rg_high_next)   rg_high_next  = rg;
            if (rb < rb_low_next)    rb_low_next   = rb;
            if (rb > rb_high_next)   rb_high_next  = rb;
        end
    end

    // Floor test against the ranges held
    assign hit = (red > red_low_reg) && (red < red_high_reg) &&
                 (rg >= rg_low_reg) && (rg <= rg_high_reg) &&
                 (rb >= rb_low_reg) && (rb <= rb_high_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            red_low_reg  <= fcrs_pkg::RedLowReset;
            red_high_reg <= '0;
            rg_low_reg   <= fcrs_pkg::DiffLowReset;
            rg_high_reg  <= '0;
            rb_low_reg   <= fcrs_pkg::DiffLowReset;
            rb_high_reg  <= '0;
        end else if (step && learn) begin
            red_low_reg  <= red_low_next;
            red_high_reg <= red_high_next;
            rg_low_reg   <= rg_low_next;
            rg_high_reg  <= rg_high_next;
            rb_low_reg   <= rb_low_next;
            rb_high_reg  <= rb_high_next;
        end
    end

endmodule

`default_nettype wire

FILE: dv/floor_color_range_segmenter_tb.sv
// Self-checking testbench for the floor colour range segmenter.
`timescale 1ns / 100ps

module floor_color_range_segmenter_tb;

    localparam int MAX_DIM     = 2048;
    localparam int PIPE_DEPTH  = 2;      // accept to result register
    localparam int STALL_LIMIT = 4000;   // cycles with no word moving

    // One classify result as the block should report it
    typedef struct packed {
        logic                        floor_mask;
        logic [fcrs_pkg::CountW-1:0] floor_count;
        logic                        frame_end;
    } seg_result_t;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    wire         s_tready;
    logic [23:0] s_tdata   = '0;     // red [7:0], green [15:8], blue [23:16]
    logic [1:0]  s_tuser   = '0;     // req_type [0], frame_start [1]
    wire         m_tvalid;
    logic        m_tready  = 1'b0;
    wire  [23:0] m_tdata;            // floor_mask [0], floor_count [23:1]
    wire         m_tlast;            // frame_end
    logic        cfg_wr_en = 1'b0;
    logic [1:0]  cfg_index = '0;
    logic [11:0] cfg_data  = '0;

    floor_color_range_segmenter #(.MAX_DIM(MAX_DIM)) DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Shadow of the block's registers and colour statistics
    logic [11:0]                       img_w_reg  = 12'd640;
    logic [11:0]                       img_h_reg  = 12'd480;
    logic [11:0]                       rect_w_reg = 12'd64;
    logic [11:0]                       rect_h_reg = 12'd32;
    logic [10:0]                       col_now    = '0;
    logic [10:0]                       row_now    = '0;
    logic [fcrs_pkg::ChanW-1:0]        red_lo     = fcrs_pkg::RedLowReset;
    logic [fcrs_pkg::ChanW-1:0]        red_hi     = '0;
    logic signed [fcrs_pkg::DiffW-1:0] rg_lo      = fcrs_pkg::DiffLowReset;
    logic signed [fcrs_pkg::DiffW-1:0] rg_hi      = '0;
    logic signed [fcrs_pkg::DiffW-1:0] rb_lo      = fcrs_pkg::DiffLowReset;
    logic signed [fcrs_pkg::DiffW-1:0] rb_hi      = '0;
    logic [fcrs_pkg::CountW-1:0]       floor_total = '0;

    seg_result_t floor_results[$];
    int          fail_count    = 0;
    int          sent_items    = 0;
    int          src_idle_pct  = 0;
    int          sink_stall_pct = 0;
    int          quiet_cycles  = 0;

    // Clock
    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // Receiver back-pressure
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= sink_stall_pct);
    end

    // Work out the segmenter's answer for one accepted pixel
    function automatic void predict_pixel(input fcrs_pkg::req_type_t kind,
                                          input logic fs,
                                          input logic [7:0] r8, g8, b8);
        int          w, h, x, y, r, rg, rb, up, left, right;
        int          rlo, rhi, glo, ghi, blo, bhi;
        logic        last_col, last_row, hit;
        seg_result_t res;
        w  = (img_w_reg > MAX_DIM) ? MAX_DIM : int'(img_w_reg);
        h  = (img_h_reg > MAX_DIM) ? MAX_DIM : int'(img_h_reg);
        r  = int'(r8);
        rg = r - int'(g8);
        rb = r - int'(b8);
        // Restart position, and statistics or count, on a frame start
        if (fs) begin
            col_now = '0;
            row_now = '0;
            if (kind == fcrs_pkg::REQ_LEARN) begin
                red_lo = fcrs_pkg::RedLowReset;
                red_hi = '0;
                rg_lo  = fcrs_pkg::DiffLowReset;
                rg_hi  = '0;
                rb_lo  = fcrs_pkg::DiffLowReset;
                rb_hi  = '0;
            end else begin
                floor_total = '0;
            end
        end
        x = int'(col_now);
        y = int'(row_now);
        rlo = red_lo;
        rhi = red_hi;
        glo = rg_lo;
        ghi = rg_hi;
        blo = rb_lo;
        bhi = rb_hi;
        // Widen the ranges with non-black pixels inside the reference rectangle
        if (kind == fcrs_pkg::REQ_LEARN) begin
            up    = h - int'(rect_h_reg);
            left  = (w - int'(rect_w_reg) - 1) / 2;
            right = (w + int'(rect_w_reg) - 1) / 2;
            if (y >= up && y < h && x >= left && x < right && (r8 | g8 | b8) != 8'd0) begin
                if (r < rlo)  red_lo = r8;
                if (r > rhi)  red_hi = r8;
                if (rg < glo) rg_lo  = rg[fcrs_pkg::DiffW-1:0];
                if (rg > ghi) rg_hi  = rg[fcrs_pkg::DiffW-1:0];
                if (rb < blo) rb_lo  = rb[fcrs_pkg::DiffW-1:0];
                if (rb > bhi) rb_hi  = rb[fcrs_pkg::DiffW-1:0];
            end
        end
        last_col = (x + 1 >= w);
        last_row = (y + 1 >= h);
        // Classify against the learned ranges
        if (kind == fcrs_pkg::REQ_CLASSIFY) begin
            hit = r > rlo && r < rhi && rg >= glo && rg <= ghi && rb >= blo && rb <= bhi;
            if (hit && floor_total != fcrs_pkg::CountMax) floor_total = floor_total + 1'b1;
            res.floor_mask  = hit;
            res.floor_count = floor_total;
            res.frame_end   = last_col && last_row;
            floor_results.push_back(res);
        end
        // Advance raster position
        if (last_col) begin
            col_now = '0;
            row_now = last_row ? 11'd0 : row_now + 1'b1;
        end else begin
            col_now = col_now + 1'b1;
        end
    endfunction

    // Offer one pixel word and wait for it to be taken
    task automatic send_pixel(input fcrs_pkg::req_type_t kind, input logic fs,
                              input logic [7:0] r, g, b);
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {b, g, r};
        s_tuser  <= {fs, kind};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predict_pixel(kind, fs, r, g, b);
        sent_items++;
    endtask

    // Hold the sender until every result is out and the pipeline is empty
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (floor_results.size() != 0) @(posedge aclk);
        repeat (PIPE_DEPTH + 2) @(posedge aclk);
    endtask

    // Write all four geometry registers back to back
    task automatic program_geometry(input logic [11:0] w, h, rw, rh);
        cfg_wr_en <= 1'b1;
        cfg_index <= fcrs_pkg::REG_IMAGE_WIDTH;
        cfg_data  <= w;
        img_w_reg  = w;
        @(posedge aclk);
        cfg_index <= fcrs_pkg::REG_IMAGE_HEIGHT;
        cfg_data  <= h;
        img_h_reg  = h;
        @(posedge aclk);
        cfg_index <= fcrs_pkg::REG_RECT_WIDTH;
        cfg_data  <= rw;
        rect_w_reg = rw;
        @(posedge aclk);
        cfg_index <= fcrs_pkg::REG_RECT_HEIGHT;
        cfg_data  <= rh;
        rect_h_reg = rh;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    function automatic logic [7:0] jitter(input logic [7:0] base);
        int v;
        v = int'(base) + int'($urandom_range(24)) - 12;
        if (v < 0)   v = 0;
        if (v > 255) v = 255;
        return v[7:0];
    endfunction

    // Mostly floor-like colours, with black and unrelated pixels mixed in
    function automatic void shade(input logic [7:0] br, bg, bb,
                                  output logic [7:0] r, g, b);
        int pick;
        pick = $urandom_range(15);
        if (pick == 0) begin
            r = 8'd0; g = 8'd0; b = 8'd0;
        end else if (pick < 3) begin
            r = 8'($urandom_range(255));
            g = 8'($urandom_range(255));
            b = 8'($urandom_range(255));
        end else begin
            r = jitter(br); g = jitter(bg); b = jitter(bb);
        end
    endfunction

    function automatic logic [11:0] extreme_dim();
        case ($urandom_range(3))
            0:       return 12'd0;
            1:       return 12'd1;
            2:       return 12'd2048;
            default: return 12'd4095;
        endcase
    endfunction

    function automatic void check_field(input string name, input int want, input int got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            fail_count++;
        end
    endfunction

    // Compare each result word with the oldest prediction
    always @(posedge aclk) begin
        seg_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (floor_results.size() == 0) begin
                $display("%0t: unexpected result word, expected none, actual %h last %b",
                         $time, m_tdata, m_tlast);
                fail_count++;
            end else begin
                want = floor_results.pop_front();
                if ({m_tdata[0], m_tdata[23:1], m_tlast} !== want) begin
                    check_field("floor_mask", int'(want.floor_mask), int'(m_tdata[0]));
                    check_field("floor_count", int'(want.floor_count), int'(m_tdata[23:1]));
                    check_field("frame_end", int'(want.frame_end), int'(m_tlast));
                    if ($isunknown({m_tdata, m_tlast})) begin
                        $display("%0t: unknown result, expected %h, actual %h", $time,
                                 want, {m_tdata[0], m_tdata[23:1], m_tlast});
                        fail_count++;
                    end
                end
            end
        end
    end

    // Watchdog on words moving
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("floor_color_range_segmenter regression: fail");
            $finish;
        end
    end

    // Classify with reset statistics: nothing may be floor
    task automatic test_empty_statistics();
        send_pixel(fcrs_pkg::REQ_CLASSIFY, 1'b1, 8'd0, 8'd0, 8'd0);
        send_pixel(fcrs_pkg::REQ_CLASSIFY, 1'b0, 8'd255, 8'd255, 8'd255);
        send_pixel(fcrs_pkg::REQ_CLASSIFY, 1'b0, 8'd255, 8'd0, 8'd0);
        send_pixel(fcrs_pkg::REQ_LEARN, 1'b0, 8'd128, 8'd1, 8'd254);
    endtask

    // Learn a 3x2 frame, classify it, then run on past the frame end
    task automatic test_learn_and_classify();
        drain_results();
        program_geometry(12'd3, 12'd2, 12'd3, 12'd2);
        send_pixel(fcrs_pkg::REQ_LEARN, 1'b1, 8'd0, 8'd0, 8'd0);
        send_pixel(fcrs_pkg::REQ_LEARN, 1'b0, 8'd10, 8'd20, 8'd5);
        send_pixel(fcrs_pkg::REQ_LEARN, 1'b0, 8'd200, 8'd100, 8'd250);
        send_pixel(fcrs_pkg::REQ_LEARN, 1'b0, 8'd255, 8'd0, 8'd255);
        send_pixel(fcrs_pkg::REQ_LEARN, 1'b0, 8'd100, 8'd50, 8'd50);
        send_pixel(fcrs_pkg::REQ_LEARN, 1'b0, 8'd7, 8'd7, 8'd7);
        send_pixel(fcrs_pkg::REQ_CLASSIFY, 1'b1, 8'd100, 8'd50, 8'd50);
        send_pixel(fcrs_pkg::REQ_CLASSIFY, 1'b0, 8'd10, 8'd5, 8'd5);
        send_pixel(fcrs_pkg::REQ_CLASSIFY, 1'b0, 8'd255, 8'd0, 8'd0);
        send_pixel(fcrs_pkg::REQ_CLASSIFY, 1'b0, 8'd128, 8'd200, 8'd128);
        send_pixel(fcrs_pkg::REQ_CLASSIFY, 1'b0, 8'd50, 8'd60, 8'd0);
        send_pixel(fcrs_pkg::REQ_CLASSIFY, 1'b0, 8'd200, 8'd255, 8'd255);
        send_pixel(fcrs_pkg::REQ_CLASSIFY, 1'b0, 8'd30, 8'd30, 8'd25);
        send_pixel(fcrs_pkg::REQ_CLASSIFY, 1'b0, 8'd30, 8'd30, 8'd25);
    endtask

    // Zero width and height: every pixel closes the frame
    task automatic test_zero_dimensions();
        drain_results();
        program_geometry(12'd0, 12'd0, 12'd0, 12'd0);
        send_pixel(fcrs_pkg::REQ_CLASSIFY, 1'b1, 8'd100, 8'd50, 8'd50);
        send_pixel(fcrs_pkg::REQ_LEARN, 1'b0, 8'd1, 8'd255, 8'd0);
        send_pixel(fcrs_pkg::REQ_CLASSIFY, 1'b0, 8'd100, 8'd50, 8'd50);
    endtask

    // Oversized image with a rectangle wider than the image
    task automatic test_oversized_image();
        drain_results();
        program_geometry(12'd4095, 12'd4095, 12'd4095, 12'd4095);
        send_pixel(fcrs_pkg::REQ_LEARN, 1'b1, 8'd1, 8'd0, 8'd0);
        send_pixel(fcrs_pkg::REQ_LEARN, 1'b0, 8'd3, 8'd0, 8'd0);
        send_pixel(fcrs_pkg::REQ_CLASSIFY, 1'b1, 8'd2, 8'd0, 8'd0);
    endtask

    // One geometry, one learn frame, then one or two classify frames
    task automatic run_scene();
        logic [11:0]         w, h, rw, rh;
        logic [7:0]          br, bg, bb, r, g, b;
        int                  w_eff, h_eff, frame_len, n;
        logic                fs, keep_start;
        fcrs_pkg::req_type_t kind;
        if ($urandom_range(9) == 0) begin
            w  = extreme_dim();
            h  = extreme_dim();
            rw = extreme_dim();
            rh = extreme_dim();
        end else begin
            w  = 12'($urandom_range(1, 10));
            h  = 12'($urandom_range(1, 6));
            rw = 12'($urandom_range(0, w + 2));
            rh = 12'($urandom_range(0, h + 2));
        end
        w_eff = (w == 0) ? 1 : ((w > MAX_DIM) ? MAX_DIM : int'(w));
        h_eff = (h == 0) ? 1 : ((h > MAX_DIM) ? MAX_DIM : int'(h));
        frame_len = w_eff * h_eff;
        drain_results();
        program_geometry(w, h, rw, rh);
        br = 8'($urandom_range(255));
        bg = 8'($urandom_range(255));
        bb = 8'($urandom_range(255));
        // Learn frame; large frames are cut short
        n = (frame_len > 64) ? $urandom_range(10, 40) : frame_len;
        for (int i = 0; i < n; i++) begin
            shade(br, bg, bb, r, g, b);
            send_pixel(fcrs_pkg::REQ_LEARN, i == 0, r, g, b);
        end
        // Classify frames, sometimes without a start flag or with stray words
        repeat ($urandom_range(1, 2)) begin
            keep_start = ($urandom_range(5) != 0);
            n = (frame_len > 64) ? $urandom_range(10, 40) : frame_len;
            for (int i = 0; i < n; i++) begin
                shade(br, bg, bb, r, g, b);
                fs = (i == 0 && keep_start) || ($urandom_range(40) == 0);
                if ($urandom_range(30) == 0) kind = fcrs_pkg::REQ_LEARN;
                else kind = fcrs_pkg::REQ_CLASSIFY;
                send_pixel(kind, fs, r, g, b);
            end
        end
    endtask

    task automatic test_random_traffic(input int src_pct, input int sink_pct,
                                       input int n_items);
        int target;
        src_idle_pct   = src_pct;
        sink_stall_pct = sink_pct;
        target = sent_items + n_items;
        while (sent_items < target) run_scene();
    endtask

    // Test sequence
    initial begin
        src_idle_pct   = 21;
        sink_stall_pct = 79;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_empty_statistics();
        test_learn_and_classify();
        test_zero_dimensions();
        test_oversized_image();
        test_random_traffic(21, 79, 430);
        test_random_traffic(79, 21, 430);
        test_random_traffic(0, 0, 430);
        // Wait out the last results, then let the pipeline settle
        drain_results();
        repeat (8) @(posedge aclk);
        if (fail_count == 0) begin
            $display("floor_color_range_segmenter regression: pass");
        end else begin
            $display("floor_color_range_segmenter regression: fail");
        end
        $finish;
    end

endmodule
